// ----- hw/rtl/glcdw_pkg.sv -----
package glcdw_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int CHIP_COLUMNS = 64;

    localparam int NUM_PAGES    = (PANEL_HEIGHT + 7) / 8;
    localparam int COL_W        = 8;
    localparam int ROW_W        = 6;
    localparam int PAGE_W       = 3;
    localparam int SHADOW_DEPTH = NUM_PAGES * PANEL_WIDTH;
    localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_SET_COLUMN = 8'h40;

    localparam logic OP_SET_CURSOR = 1'b0;
    localparam logic OP_WRITE_BYTE = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] target_column;
        logic [7:0] target_row;
        logic [7:0] pixel_byte;
    } glcdw_in_t;

    typedef struct packed {
        logic       target_chip;
        logic       is_data;
        logic [7:0] bus_value;
        logic       last_of_run;
    } glcdw_out_t;

    typedef enum logic {
        JOB_MOVE  = 1'b0,
        JOB_WRITE = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
    } job_t;

endpackage

// ----- hw/rtl/glcdw_front.sv -----
module glcdw_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  glcdw_pkg::glcdw_in_t in_item,
    input  logic                 q_full,
    input  logic                 clearing,
    output logic                 push,
    output glcdw_pkg::job_t      push_job
);
    import glcdw_pkg::*;

    logic accept;
    logic drop;

    assign in_stall = q_full || clearing;
    assign accept   = in_valid && !in_stall;

    // A cursor move off the panel has no effect at all, so it never enters the queue.
    assign drop = (in_item.operation == OP_SET_CURSOR) &&
                  ((in_item.target_column >= PANEL_WIDTH) ||
                   (in_item.target_row >= PANEL_HEIGHT));

    assign push = accept && !drop;

    always_comb
    begin
        push_job.kind = (in_item.operation == OP_WRITE_BYTE) ? JOB_WRITE : JOB_MOVE;
        push_job.col  = in_item.target_column;
        push_job.row  = in_item.target_row[ROW_W-1:0];
        push_job.data = in_item.pixel_byte;
    end

endmodule

// ----- hw/rtl/glcdw_queue.sv -----
module glcdw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  glcdw_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output glcdw_pkg::job_t pop_job
);
    import glcdw_pkg::*;

    job_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_job = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/glcdw_back.sv -----
module glcdw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  q_valid,
    input  glcdw_pkg::job_t       q_job,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  out_valid,
    input  logic                  out_stall,
    output glcdw_pkg::glcdw_out_t out_item
);
    import glcdw_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_MOVE   = 8'b0000_0100,
        ST_PAGE1  = 8'b0000_1000,
        ST_COLCMD = 8'b0001_0000,
        ST_UPPER  = 8'b0010_0000,
        ST_READ   = 8'b0100_0000,
        ST_MERGE  = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE  = 2'b00,
        RET_UPPER = 2'b01,
        RET_LOWER = 2'b10
    } ret_t;

    state_t               state_reg,   state_next;
    ret_t                 ret_reg,     ret_next;
    logic                 invert_reg;
    logic [COL_W-1:0]     cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic [PAGE_W-1:0]    cur_page_reg, cur_page_next;
    logic [COL_W-1:0]     job_col_reg, job_col_next;
    logic [ROW_W-1:0]     job_row_reg, job_row_next;
    logic [7:0]           data_reg,    data_next;
    logic                 half_reg,    half_next;
    logic [COL_W-1:0]     mv_col_reg,  mv_col_next;
    logic [ROW_W-1:0]     mv_row_reg,  mv_row_next;
    logic                 mv_last_reg, mv_last_next;
    logic [SHADOW_AW-1:0] clr_idx_reg, clr_idx_next;
    logic                 out_valid_reg;
    glcdw_out_t           out_item_reg;
    logic [7:0]           rd_data_reg;

    logic [7:0]           shadow_mem [SHADOW_DEPTH];

    logic                 can_emit;
    logic                 emit;
    glcdw_out_t           emit_item;
    logic                 wr_en;
    logic [SHADOW_AW-1:0] wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [SHADOW_AW-1:0] sh_addr;
    logic [PAGE_W-1:0]    sh_page;
    logic [2:0]           offset;
    logic [3:0]           shift_lo;
    logic [7:0]           bits_up;
    logic [7:0]           bits_lo;
    logic [7:0]           merge_bits;
    logic [7:0]           merged;
    logic [7:0]           aligned_raw;
    logic                 lower_fits;
    logic                 next_fits;
    logic [COL_W-1:0]     col_inc;
    logic                 job_chip;
    logic [PAGE_W-1:0]    mv_page;
    logic                 page_change;
    logic                 boundary;
    state_t               ret_state;

    assign can_emit    = !out_valid_reg || !out_stall;
    assign offset      = job_row_reg[2:0];
    assign sh_page     = job_row_reg[ROW_W-1:3] + PAGE_W'(half_reg);
    assign sh_addr     = SHADOW_AW'(sh_page) * SHADOW_AW'(PANEL_WIDTH) + SHADOW_AW'(job_col_reg);
    assign shift_lo    = 4'd8 - {1'b0, offset};
    assign bits_up     = data_reg << offset;
    assign bits_lo     = data_reg >> shift_lo;
    assign merge_bits  = half_reg ? bits_lo : bits_up;
    assign merged      = invert_reg ? (rd_data_reg & ~merge_bits) : (rd_data_reg | merge_bits);
    assign aligned_raw = invert_reg ? ~data_reg : data_reg;
    assign lower_fits  = ({1'b0, job_row_reg} + 7'd8) < 7'(PANEL_HEIGHT);
    assign next_fits   = ({1'b0, job_col_reg} + 9'd1) < 9'(PANEL_WIDTH);
    assign col_inc     = job_col_reg + 1'b1;
    assign job_chip    = 1'(job_col_reg / CHIP_COLUMNS);
    assign mv_page     = mv_row_reg[ROW_W-1:3];
    assign page_change = (mv_page != cur_page_reg);
    assign boundary    = ((cur_col_reg % CHIP_COLUMNS) == 0) && ((cur_col_reg / CHIP_COLUMNS) != 0);

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        case (ret_reg)
            RET_UPPER: ret_state = ST_UPPER;
            RET_LOWER: ret_state = ST_READ;
            default:   ret_state = ST_IDLE;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        cur_page_next = cur_page_reg;
        job_col_next  = job_col_reg;
        job_row_next  = job_row_reg;
        data_next     = data_reg;
        half_next     = half_reg;
        mv_col_next   = mv_col_reg;
        mv_row_next   = mv_row_reg;
        mv_last_next  = mv_last_reg;
        clr_idx_next  = clr_idx_reg;
        emit          = 1'b0;
        emit_item     = '0;
        wr_en         = 1'b0;
        wr_addr       = sh_addr;
        wr_data       = merged;
        rd_en         = 1'b0;
        q_pop         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SHADOW_AW'(SHADOW_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_job.kind == JOB_MOVE)
                    begin
                        mv_col_next  = q_job.col;
                        mv_row_next  = q_job.row;
                        mv_last_next = 1'b1;
                        ret_next     = RET_IDLE;
                        cur_col_next = q_job.col;
                        cur_row_next = q_job.row;
                        state_next   = ST_MOVE;
                    end
                    else if (cur_col_reg < PANEL_WIDTH)
                    begin
                        job_col_next = cur_col_reg;
                        job_row_next = cur_row_reg;
                        data_next    = q_job.data;
                        half_next    = 1'b0;
                        if (boundary)
                        begin
                            // Entering a new chip: the address is sent again first.
                            mv_col_next  = cur_col_reg;
                            mv_row_next  = cur_row_reg;
                            mv_last_next = 1'b0;
                            ret_next     = RET_UPPER;
                            state_next   = ST_MOVE;
                        end
                        else
                        begin
                            state_next = ST_UPPER;
                        end
                    end
                end
            end

            ST_MOVE:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (page_change)
                    begin
                        emit_item.target_chip = 1'b0;
                        emit_item.is_data     = 1'b0;
                        emit_item.bus_value   = CMD_SET_PAGE | 8'(mv_page);
                        emit_item.last_of_run = 1'b0;
                        state_next            = ST_PAGE1;
                    end
                    else
                    begin
                        emit_item.target_chip = 1'(mv_col_reg / CHIP_COLUMNS);
                        emit_item.is_data     = 1'b0;
                        emit_item.bus_value   = CMD_SET_COLUMN | 8'(mv_col_reg % CHIP_COLUMNS);
                        emit_item.last_of_run = mv_last_reg;
                        state_next            = ret_state;
                    end
                end
            end

            ST_PAGE1:
            begin
                if (can_emit)
                begin
                    emit                  = 1'b1;
                    emit_item.target_chip = 1'b1;
                    emit_item.is_data     = 1'b0;
                    emit_item.bus_value   = CMD_SET_PAGE | 8'(mv_page);
                    emit_item.last_of_run = 1'b0;
                    cur_page_next         = mv_page;
                    state_next            = ST_COLCMD;
                end
            end

            ST_COLCMD:
            begin
                if (can_emit)
                begin
                    emit                  = 1'b1;
                    emit_item.target_chip = 1'(mv_col_reg / CHIP_COLUMNS);
                    emit_item.is_data     = 1'b0;
                    emit_item.bus_value   = CMD_SET_COLUMN | 8'(mv_col_reg % CHIP_COLUMNS);
                    emit_item.last_of_run = mv_last_reg;
                    state_next            = ret_state;
                end
            end

            ST_UPPER:
            begin
                if (offset == 3'd0)
                begin
                    if (can_emit)
                    begin
                        emit                  = 1'b1;
                        emit_item.target_chip = job_chip;
                        emit_item.is_data     = 1'b1;
                        emit_item.bus_value   = aligned_raw;
                        emit_item.last_of_run = 1'b1;
                        wr_en                 = 1'b1;
                        wr_data               = aligned_raw;
                        cur_col_next          = col_inc;
                        state_next            = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_MERGE;
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                if (can_emit)
                begin
                    emit                  = 1'b1;
                    emit_item.target_chip = job_chip;
                    emit_item.is_data     = 1'b1;
                    emit_item.bus_value   = merged;
                    emit_item.last_of_run = !next_fits && (half_reg || !lower_fits);
                    wr_en                 = 1'b1;
                    if (!half_reg && lower_fits)
                    begin
                        half_next    = 1'b1;
                        mv_col_next  = job_col_reg;
                        mv_row_next  = job_row_reg + 6'd8;
                        mv_last_next = 1'b0;
                        ret_next     = RET_LOWER;
                        cur_col_next = job_col_reg;
                        cur_row_next = job_row_reg + 6'd8;
                        state_next   = ST_MOVE;
                    end
                    else if (next_fits)
                    begin
                        mv_col_next  = col_inc;
                        mv_row_next  = job_row_reg;
                        mv_last_next = 1'b1;
                        ret_next     = RET_IDLE;
                        cur_col_next = col_inc;
                        cur_row_next = job_row_reg;
                        state_next   = ST_MOVE;
                    end
                    else
                    begin
                        // The cursor moves off the right edge without any commands.
                        cur_col_next = col_inc;
                        cur_row_next = job_row_reg;
                        state_next   = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= RET_IDLE;
            invert_reg    <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_page_reg  <= '0;
            half_reg      <= 1'b0;
            mv_last_reg   <= 1'b0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            cur_page_reg <= cur_page_next;
            half_reg     <= half_next;
            mv_last_reg  <= mv_last_next;
            clr_idx_reg  <= clr_idx_next;
            if (cfg_we)
            begin
                invert_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_col_reg <= job_col_next;
        job_row_reg <= job_row_next;
        data_reg    <= data_next;
        mv_col_reg  <= mv_col_next;
        mv_row_reg  <= mv_row_next;
        if (emit)
        begin
            out_item_reg <= emit_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shadow_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= shadow_mem[sh_addr];
        end
    end

endmodule

// ----- hw/rtl/glcd_column_byte_writer_core.sv -----
// Write controller for a 128x64 panel made of two 64-column page-organized controller chips.
// An input beat either moves the cursor or writes one vertical byte of eight pixels, and each
// output beat is one bus transaction (chip, command or data, byte), with last_of_run marking the
// final transaction of an input. After reset the panel shadow memory is cleared one entry per
// cycle, and in_stall stays high during that time, while invert_mode can still be written.
// Inputs enter a four-entry queue and are then carried out one at a time by a sequencer, which
// holds each transaction while the output is stalled. A cursor move sends set-page to both
// chips when the page changes and then set-column; an aligned write sends its byte, with the
// column address sent again first at the first column of the right chip; and a write at a row
// that is not a multiple of eight reads the shadow memory for each of its pages before the merged byte is sent.
module glcd_column_byte_writer_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  glcdw_pkg::glcdw_in_t  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output glcdw_pkg::glcdw_out_t out_item
);
    import glcdw_pkg::*;

    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_valid;
    job_t q_pop_job;
    logic clearing;

    glcdw_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (q_push),
        .push_job (q_push_job)
    );

    glcdw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (q_pop_job)
    );

    glcdw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_job     (q_pop_job),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- hw/rtl/glcdw_checker.sv -----
module glcdw_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input glcdw_pkg::glcdw_out_t out_item
);
    import glcdw_pkg::*;

    logic set_page_beat;

    assign set_page_beat = out_valid && !out_item.is_data &&
                           (out_item.bus_value[7:3] == CMD_SET_PAGE[7:3]);

    // A stalled beat stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output beat changed while stalled");

    // The left chip's set-page is followed at once by the same set-page to the right chip.
    assert property (@(posedge clk) disable iff (!rst_n)
        set_page_beat && !out_stall && !out_item.target_chip |=>
            set_page_beat && out_item.target_chip &&
            (out_item.bus_value == $past(out_item.bus_value)))
        else $error("set-page not repeated to the right chip");

    // A run always ends with a data byte or a set-column command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_of_run |->
            out_item.is_data || (out_item.bus_value[7:6] == CMD_SET_COLUMN[7:6]))
        else $error("run ends on a set-page command");

endmodule

bind glcd_column_byte_writer_core glcdw_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// ----- sim/glcd_column_byte_writer_core_tb.sv -----
module glcd_column_byte_writer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import glcdw_pkg::*;

    localparam int CHIP_COUNT = PANEL_WIDTH / CHIP_COLUMNS;
    localparam int MAX_TXNS = 10;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT = 5000;
    localparam int IN_W = $bits(glcdw_in_t);

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    glcdw_in_t  in_item;
    logic       out_valid;
    logic       out_stall;
    glcdw_out_t out_item;

    logic [COL_W-1:0]  model_col;
    logic [ROW_W-1:0]  model_row;
    logic [PAGE_W-1:0] model_page;
    logic              model_invert;
    logic [7:0]        shadow_img [SHADOW_DEPTH];

    glcdw_out_t run_beats[$];
    glcdw_out_t bus_expected[$];

    int  live_items;
    int  fail_count;
    int  shown_count;
    bit  no_idle;

    glcd_column_byte_writer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void post_txn(int chip, bit data, logic [7:0] value);
        glcdw_out_t t;
        t.target_chip = chip[0];
        t.is_data     = data;
        t.bus_value   = value;
        t.last_of_run = 1'b0;
        if (run_beats.size() < MAX_TXNS)
        begin
            run_beats.push_back(t);
        end
    endfunction

    function automatic void place_cursor(int x, int y);
        int chip;
        if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT)
        begin
            return;
        end
        model_col = COL_W'(x);
        model_row = ROW_W'(y);
        if (y / 8 != model_page)
        begin
            model_page = PAGE_W'(y / 8);
            for (chip = 0; chip < CHIP_COUNT; chip++)
            begin
                post_txn(chip, 1'b0, CMD_SET_PAGE | model_page);
            end
        end
        post_txn(x / CHIP_COLUMNS, 1'b0, CMD_SET_COLUMN | 8'(x % CHIP_COLUMNS));
    endfunction

    function automatic logic [7:0] merge_pixels(int page, int col, logic [7:0] bits);
        int idx;
        logic [7:0] raw;
        idx = page * PANEL_WIDTH + col;
        if (idx >= SHADOW_DEPTH)
        begin
            return 8'h00;
        end
        raw = model_invert ? (shadow_img[idx] & ~bits) : (shadow_img[idx] | bits);
        shadow_img[idx] = raw;
        return raw;
    endfunction

    function automatic void write_pixels(logic [7:0] data);
        int col;
        int row;
        int chip;
        int off;
        int page;
        int idx;
        logic [7:0] raw;
        logic [7:0] upper;
        logic [7:0] lower;
        col = model_col;
        row = model_row;
        if (col >= PANEL_WIDTH)
        begin
            return;
        end
        chip = col / CHIP_COLUMNS;
        if (col % CHIP_COLUMNS == 0 && chip > 0)
        begin
            place_cursor(col, row);
        end
        off  = row % 8;
        page = row / 8;
        if (off == 0)
        begin
            raw = model_invert ? ~data : data;
            idx = page * PANEL_WIDTH + col;
            if (idx < SHADOW_DEPTH)
            begin
                shadow_img[idx] = raw;
            end
            post_txn(chip, 1'b1, raw);
            model_col = COL_W'(col + 1);
            return;
        end
        upper = data << off;
        lower = data >> (8 - off);
        post_txn(chip, 1'b1, merge_pixels(page, col, upper));
        if (row + 8 < PANEL_HEIGHT)
        begin
            place_cursor(col, row + 8);
            post_txn(chip, 1'b1, merge_pixels(page + 1, col, lower));
        end
        if (col + 1 < PANEL_WIDTH)
        begin
            place_cursor(col + 1, row);
        end
        else
        begin
            model_col = COL_W'(col + 1);
            model_row = ROW_W'(row);
        end
    endfunction

    function automatic void predict_beat(glcdw_in_t it);
        glcdw_out_t t;
        run_beats.delete();
        if (it.operation == OP_SET_CURSOR)
        begin
            place_cursor(it.target_column, it.target_row);
        end
        else
        begin
            write_pixels(it.pixel_byte);
        end
        if (run_beats.size() > 0)
        begin
            t = run_beats.pop_back();
            t.last_of_run = 1'b1;
            run_beats.push_back(t);
            live_items++;
        end
        foreach (run_beats[i])
        begin
            bus_expected.push_back(run_beats[i]);
        end
    endfunction

    always @(posedge clk)
    begin : check_output
        glcdw_out_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (bus_expected.size() == 0)
            begin
                fail_count++;
                shown_count++;
                if (shown_count <= 10)
                begin
                    $display("unexpected beat: chip %0d data %0d value %02h last %0d",
                             out_item.target_chip, out_item.is_data, out_item.bus_value,
                             out_item.last_of_run);
                end
            end
            else
            begin
                want = bus_expected.pop_front();
                if (out_item !== want)
                begin
                    fail_count++;
                    shown_count++;
                    if (shown_count <= 10)
                    begin
                        $display("mismatch: expected %0d/%0d/%02h/%0d got %0d/%0d/%02h/%0d",
                                 want.target_chip, want.is_data, want.bus_value,
                                 want.last_of_run, out_item.target_chip, out_item.is_data,
                                 out_item.bus_value, out_item.last_of_run);
                    end
                end
            end
        end
        out_stall <= !no_idle && ($urandom_range(0, 99) < 11);
    end

    task automatic send_beat(input glcdw_in_t it);
        begin
            while (!no_idle && $urandom_range(0, 99) < 11)
            begin
                in_valid <= 1'b0;
                in_item  <= IN_W'($urandom);
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item  <= it;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            predict_beat(it);
        end
    endtask

    task automatic send_cursor(input int col, input int row);
        glcdw_in_t it;
        begin
            it.operation     = OP_SET_CURSOR;
            it.target_column = 8'(col);
            it.target_row    = 8'(row);
            it.pixel_byte    = 8'($urandom);
            send_beat(it);
        end
    endtask

    task automatic send_pixels(input logic [7:0] data);
        glcdw_in_t it;
        begin
            it               = IN_W'($urandom);
            it.operation     = OP_WRITE_BYTE;
            it.pixel_byte    = data;
            send_beat(it);
        end
    endtask

    task automatic drain_block();
        int waited;
        begin
            in_valid <= 1'b0;
            waited = 0;
            while (bus_expected.size() != 0 && waited < DRAIN_LIMIT)
            begin
                @(posedge clk);
                waited++;
            end
            if (bus_expected.size() != 0)
            begin
                fail_count += bus_expected.size();
                shown_count++;
                if (shown_count <= 10)
                begin
                    $display("%0d expected beats never arrived", bus_expected.size());
                end
                bus_expected.delete();
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_invert(input bit value);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
            model_invert = value;
        end
    endtask

    task automatic test_cursor_moves();
        begin
            send_cursor(5, 0);
            send_cursor(127, 63);
            send_cursor(128, 10);
            send_cursor(20, 64);
            send_cursor(255, 255);
            send_cursor(64, 17);
        end
    endtask

    task automatic test_aligned_writes();
        begin
            send_cursor(62, 8);
            send_pixels(8'h00);
            send_pixels(8'hFF);
            send_pixels(8'hA5);
            send_cursor(127, 56);
            send_pixels(8'h3C);
            send_pixels(8'h77);
        end
    endtask

    task automatic test_unaligned_writes();
        begin
            send_cursor(63, 5);
            send_pixels(8'h5A);
            send_pixels(8'hC3);
            send_cursor(127, 61);
            send_pixels(8'h81);
            send_cursor(30, 60);
            send_pixels(8'hFF);
        end
    endtask

    task automatic test_invert_mode();
        begin
            drain_block();
            write_invert(1'b1);
            send_cursor(63, 5);
            send_pixels(8'h18);
            send_cursor(0, 0);
            send_pixels(8'h0F);
        end
    endtask

    task automatic test_random_traffic(input int items, input bit invert, input bit steady);
        glcdw_in_t it;
        int target;
        int col;
        int row;
        int writes;
        begin
            drain_block();
            write_invert(invert);
            no_idle = steady;
            target = live_items + items;
            while (live_items < target)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        it = IN_W'($urandom);
                        it.operation = OP_SET_CURSOR;
                        send_beat(it);
                    end
                    1:
                    begin
                        send_pixels(8'($urandom));
                    end
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: col = $urandom_range(60, 67);
                            1: col = $urandom_range(122, 127);
                            default: col = $urandom_range(0, 127);
                        endcase
                        if ($urandom_range(0, 1) == 0)
                        begin
                            row = $urandom_range(0, 7) * 8;
                        end
                        else
                        begin
                            row = $urandom_range(0, 63);
                        end
                        send_cursor(col, row);
                        writes = $urandom_range(1, 6);
                        repeat (writes) send_pixels(8'($urandom));
                    end
                endcase
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        no_idle      = 1'b0;
        live_items   = 0;
        fail_count   = 0;
        shown_count  = 0;
        model_col    = '0;
        model_row    = '0;
        model_page   = '0;
        model_invert = 1'b0;
        foreach (shadow_img[i])
        begin
            shadow_img[i] = 8'h00;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_invert(1'b0);
        test_cursor_moves();
        test_aligned_writes();
        test_unaligned_writes();
        test_invert_mode();
        test_random_traffic(80, 1'b0, 1'b0);
        test_random_traffic(80, 1'b1, 1'b0);
        test_random_traffic(80, 1'b1, 1'b1);
        test_random_traffic(80, 1'b0, 1'b0);
        drain_block();
        if (fail_count == 0)
        begin
            $display("glcd_column_byte_writer_core regression: pass");
        end
        else
        begin
            $display("glcd_column_byte_writer_core regression: fail");
        end
        $finish;
    end

    initial
    begin
        #500000;
        $display("glcd_column_byte_writer_core regression: fail");
        $finish;
    end

endmodule
